// ===== hdl/rpa_pkg.sv =====
`default_nettype none

package rpa_pkg;

	// Sizing of the managed window and of the count store
	localparam int PAGE_COUNT  = 4096;
	localparam int PAGE_SHIFT  = 12;
	localparam int COUNT_WIDTH = 8;

	// Field widths fixed by the interface
	localparam int ADDR_W      = 32;
	localparam int KIND_W      = 3;
	localparam int STATUS_W    = 3;
	localparam int COUNT_OUT_W = 8;
	localparam int LOWEST_W    = 20;
	localparam int TOP_W       = 21;
	localparam int REG_W       = 32;
	localparam int PADDR_W     = 3;
	localparam int OUT_DATA_W  = 48;
	localparam int OUT_PAD_W   = OUT_DATA_W - ADDR_W - COUNT_OUT_W - 1;

	// Derived widths
	localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
	localparam int SLOT_W      = $clog2(PAGE_COUNT);
	localparam int DEPTH_W     = $clog2(PAGE_COUNT + 1);
	localparam int CMP_W       = ((PAGE_NUM_W > TOP_W) ? PAGE_NUM_W : TOP_W) + 1;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

	// Request kinds on the input stream
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FREE    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD_REF = 3'd2;
	localparam logic [KIND_W-1:0] KIND_GET_REF = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SEED    = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MEM      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SATURATED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 3'd5;

	// Register index (address bit 2)
	localparam logic REG_LOWEST = 1'b0;
	localparam logic REG_TOP    = 1'b1;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Operation after classification
	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_FREE,
		OP_ADD_REF,
		OP_GET_REF,
		OP_SEED,
		OP_BAD_ADDR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [PAGE_NUM_W-1:0] page;
		logic [SLOT_W-1:0]     slot;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [ADDR_W-1:0]      page_address;
		logic [COUNT_OUT_W-1:0] ref_count;
		logic                   page_released;
	} rsp_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} win_t;

	// Position of a page in the window above lowest; top is checked apart
	function automatic win_t window_slot(input logic [PAGE_NUM_W-1:0] page,
			input logic [LOWEST_W-1:0] lowest);
		logic [CMP_W-1:0] p;
		logic [CMP_W-1:0] l;
		logic [CMP_W-1:0] d;
		win_t             w;
		p = CMP_W'(page);
		l = CMP_W'(lowest);
		d = p - l;
		w.hit  = (p >= l) && (d < CMP_W'(PAGE_COUNT));
		w.slot = d[SLOT_W-1:0];
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rpa_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module rpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/rpa_front.sv =====
`default_nettype none

// Accepts requests, checks the address and turns the kind into an operation
module rpa_front import rpa_pkg::*; (
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [ADDR_W-1:0]   address,
	input  wire logic [LOWEST_W-1:0] lowest_page,
	input  wire logic [TOP_W-1:0]    top_page,
	output req_t                     req
);

	logic [PAGE_NUM_W-1:0] page;
	logic                  aligned;
	logic                  below_top;
	logic                  in_range;
	win_t                  win;

	// Page number, alignment and window test
	always_comb begin
		page      = address[ADDR_W-1:PAGE_SHIFT];
		aligned   = (address[PAGE_SHIFT-1:0] == '0);
		win       = window_slot(page, lowest_page);
		below_top = (CMP_W'(page) < CMP_W'(top_page));
		in_range  = win.hit && below_top;
	end

	// Classify
	always_comb begin
		req.page = page;
		req.slot = win.slot;
		case (kind)
			KIND_ALLOC:   req.op = OP_ALLOC;
			KIND_FREE:    req.op = (in_range && aligned) ? OP_FREE : OP_BAD_ADDR;
			KIND_ADD_REF: req.op = (in_range && aligned) ? OP_ADD_REF : OP_BAD_ADDR;
			KIND_SEED:    req.op = (in_range && aligned) ? OP_SEED : OP_BAD_ADDR;
			KIND_GET_REF: req.op = in_range ? OP_GET_REF : OP_BAD_ADDR;
			default:      req.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/rpa_queue.sv =====
`default_nettype none

// Short request queue, head shown ahead
module rpa_queue import rpa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_req,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output req_t      head
);

	req_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rpa_back.sv =====
`default_nettype none

// Executes requests against the count store and the free stack
module rpa_back import rpa_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [LOWEST_W-1:0] lowest_page,
	input  wire logic                q_empty,
	input  wire req_t                q_head,
	output logic                     q_pop,
	output logic                     clearing,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rsp_t                     out_rsp
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_ISSUE = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t               state_q;
	logic [SLOT_W-1:0]    clr_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [DEPTH_W-1:0]   depth_m1;
	req_t                 cur_q;
	logic                 out_valid_q;
	rsp_t                 out_rsp_q;

	// Count store ports
	logic                   cnt_we;
	logic [SLOT_W-1:0]      cnt_waddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic [COUNT_WIDTH-1:0] cnt_rd;

	// Free stack ports
	logic                  stk_push;
	logic                  stk_pop;
	logic [PAGE_NUM_W-1:0] stk_rd;

	// Execute results
	logic                   ex_we;
	logic [SLOT_W-1:0]      ex_slot;
	logic [COUNT_WIDTH-1:0] ex_wdata;
	logic [STATUS_W-1:0]    ex_status;
	logic [ADDR_W-1:0]      ex_paddr;
	logic [COUNT_WIDTH-1:0] ex_count;
	logic                   ex_rel;
	logic                   ex_push;
	logic                   ex_pop;
	logic [COUNT_WIDTH+COUNT_OUT_W-1:0] ex_count_ext;
	logic                   stack_empty;
	logic                   stack_full;
	logic                   is_exec;
	win_t                   pop_win;

	assign clearing    = (state_q == ST_CLEAR);
	assign is_exec     = (state_q == ST_EXEC);
	assign q_pop       = (state_q == ST_ISSUE) && !q_empty && (!out_valid_q || out_ready);
	assign depth_m1    = depth_q - DEPTH_W'(1);
	assign stack_empty = (depth_q == '0);
	assign stack_full  = (depth_q >= DEPTH_W'(PAGE_COUNT));
	assign out_valid   = out_valid_q;
	assign out_rsp     = out_rsp_q;

	rpa_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(PAGE_COUNT)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(q_head.slot),
		.rdata(cnt_rd)
	);

	rpa_ram #(
		.WIDTH(PAGE_NUM_W),
		.DEPTH(PAGE_COUNT)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_push),
		.waddr(depth_q[SLOT_W-1:0]),
		.wdata(cur_q.page),
		.raddr(depth_m1[SLOT_W-1:0]),
		.rdata(stk_rd)
	);

	// Operation logic, read data valid in the execute cycle
	always_comb begin
		ex_we     = 1'b0;
		ex_slot   = cur_q.slot;
		ex_wdata  = '0;
		ex_status = ST_OK;
		ex_paddr  = '0;
		ex_count  = '0;
		ex_rel    = 1'b0;
		ex_push   = 1'b0;
		ex_pop    = 1'b0;
		pop_win   = window_slot(stk_rd, lowest_page);
		case (cur_q.op)
			OP_ALLOC: begin
				if (stack_empty) begin
					ex_status = ST_NO_MEM;
				end else begin
					ex_pop   = 1'b1;
					ex_paddr = {stk_rd, {PAGE_SHIFT{1'b0}}};
					ex_we    = pop_win.hit;
					ex_slot  = pop_win.slot;
					ex_wdata = COUNT_ONE;
					ex_count = COUNT_ONE;
				end
			end
			OP_FREE: begin
				ex_count = cnt_rd;
				if (cnt_rd == '0) begin
					ex_status = ST_DOUBLE_FREE;
				end else if (cnt_rd == COUNT_ONE) begin
					if (stack_full) begin
						ex_status = ST_STACK_FULL;
					end else begin
						ex_push  = 1'b1;
						ex_we    = 1'b1;
						ex_count = '0;
						ex_rel   = 1'b1;
					end
				end else begin
					ex_count = cnt_rd - COUNT_ONE;
					ex_we    = 1'b1;
					ex_wdata = cnt_rd - COUNT_ONE;
				end
			end
			OP_ADD_REF: begin
				if (cnt_rd == COUNT_MAX) begin
					ex_status = ST_SATURATED;
					ex_count  = COUNT_MAX;
				end else begin
					ex_count = cnt_rd + COUNT_ONE;
					ex_we    = 1'b1;
					ex_wdata = cnt_rd + COUNT_ONE;
				end
			end
			OP_GET_REF: begin
				ex_count = cnt_rd;
			end
			OP_SEED: begin
				if (stack_full) begin
					ex_status = ST_STACK_FULL;
					ex_count  = cnt_rd;
				end else begin
					ex_push = 1'b1;
					ex_we   = 1'b1;
					ex_rel  = 1'b1;
				end
			end
			OP_BAD_ADDR: begin
				ex_status = ST_BAD_ADDR;
			end
			default: begin
				ex_status = ST_OK;
			end
		endcase
		ex_count_ext = (COUNT_WIDTH + COUNT_OUT_W)'(ex_count);
	end

	// Count store write: clearing pass or execute
	always_comb begin
		if (clearing) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = is_exec && ex_we;
			cnt_waddr = ex_slot;
			cnt_wdata = ex_wdata;
		end
	end

	assign stk_push = is_exec && ex_push;
	assign stk_pop  = is_exec && ex_pop;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(PAGE_COUNT - 1)) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_ISSUE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (stk_push) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (stk_pop) begin
				depth_q <= depth_m1;
			end
			if (is_exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Current request and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (is_exec) begin
			out_rsp_q.status        <= ex_status;
			out_rsp_q.page_address  <= ex_paddr;
			out_rsp_q.ref_count     <= ex_count_ext[COUNT_OUT_W-1:0];
			out_rsp_q.page_released <= ex_rel;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/refcounted_page_allocator.sv =====
`default_nettype none

// Channel   Handshake                     Payload
// s_axis    s_axis_tvalid/s_axis_tready   tuser: kind; tdata: address
// m_axis    m_axis_tvalid/m_axis_tready   tuser: status; tdata: address, count, released
// apb       psel/penable/pready           0x0 lowest_page, 0x4 top_page
//
// In the execute unit each request is first issued, which reads the count store
// and the free stack, then executed, which updates them and loads the result register.
// After reset a clearing pass zeroes the count store, one entry a cycle;
// no request is taken until it ends.
// A two-entry queue sits between classification and execution; a pending
// result stalls the execute unit, and the input side stalls once the queue fills.
module refcounted_page_allocator import rpa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [ADDR_W-1:0]     s_axis_tdata,   // [31:0] address
	input  wire logic [KIND_W-1:0]     s_axis_tuser,   // [2:0] kind

	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [31:0] page_address, [39:32] ref_count,
	                                                   // [40] page_released, [47:41] zero
	output logic [STATUS_W-1:0]        m_axis_tuser,   // [2:0] status

	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [REG_W-1:0]      pwdata,
	output logic [REG_W-1:0]           prdata,
	output logic                       pready
);

	logic [LOWEST_W-1:0] lowest_page_q;
	logic [TOP_W-1:0]    top_page_q;
	logic                reg_sel;
	logic                cfg_write;

	req_t front_req;
	req_t q_head;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic clearing;
	logic in_take;
	rsp_t rsp;

	// Configuration registers
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_page_q <= '0;
			top_page_q    <= '0;
		end else if (cfg_write) begin
			if (reg_sel == REG_LOWEST) begin
				lowest_page_q <= pwdata[LOWEST_W-1:0];
			end else begin
				top_page_q <= pwdata[TOP_W-1:0];
			end
		end
	end

	assign prdata = (reg_sel == REG_TOP) ? REG_W'(top_page_q) : REG_W'(lowest_page_q);

	// Input side
	assign s_axis_tready = !q_full && !clearing;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	rpa_front u_front (
		.kind       (s_axis_tuser),
		.address    (s_axis_tdata),
		.lowest_page(lowest_page_q),
		.top_page   (top_page_q),
		.req        (front_req)
	);

	rpa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_take),
		.push_req(front_req),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	rpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.lowest_page(lowest_page_q),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_rsp    (rsp)
	);

	// Output packing
	assign m_axis_tuser = rsp.status;
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, rsp.page_released, rsp.ref_count,
		rsp.page_address};

endmodule

`default_nettype wire

// ===== sim/refcounted_page_allocator_tb.sv =====
`timescale 1ns / 100ps

module refcounted_page_allocator_tb;
	import rpa_pkg::*;

	localparam int          CLK_HALF      = 6;
	localparam int          RESET_CYCLES  = 6;
	localparam int          MAX_GAP       = 12;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          STRETCH       = 64;
	localparam int          REPORT_MAX    = 10;
	localparam int unsigned LIMIT_CYCLES  = 1_000_000;

	localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_SEED + 1'b1;
	localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

	localparam int unsigned LOWEST_MAX = 20'hF_FFFF;
	localparam int unsigned TOP_MAX    = 21'h10_0000;
	localparam int unsigned DIR_LOWEST = 16;
	localparam int unsigned DIR_TOP    = DIR_LOWEST + PAGE_COUNT;
	localparam int          CFG_ROW    = 2;

	localparam rsp_t NO_REPLY = '0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] addr;
		logic              typed;
		rsp_t              rsp;
	} dir_row_t;

	// Window for rows from CFG_ROW on: pages 16 .. 4111
	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{KIND_ALLOC,     32'h0000_0000, 1'b1, '{ST_NO_MEM,      32'h0, 8'd0, 1'b0}},
		'{KIND_GET_REF,   32'h0000_0000, 1'b1, '{ST_BAD_ADDR,    32'h0, 8'd0, 1'b0}},
		'{KIND_GET_REF,   32'h0001_0000, 1'b1, '{ST_OK,          32'h0, 8'd0, 1'b0}},
		'{KIND_FREE,      32'h0001_0000, 1'b1, '{ST_DOUBLE_FREE, 32'h0, 8'd0, 1'b0}},
		'{KIND_FREE,      32'h0001_0001, 1'b1, '{ST_BAD_ADDR,    32'h0, 8'd0, 1'b0}},
		'{KIND_GET_REF,   32'h0001_0FFF, 1'b1, '{ST_OK,          32'h0, 8'd0, 1'b0}},
		'{KIND_ADD_REF,   32'h0000_F000, 1'b1, '{ST_BAD_ADDR,    32'h0, 8'd0, 1'b0}},
		'{KIND_SEED,      32'h0101_0000, 1'b1, '{ST_BAD_ADDR,    32'h0, 8'd0, 1'b0}},
		'{KIND_SEED,      32'h0100_F000, 1'b1, '{ST_OK,          32'h0, 8'd0, 1'b1}},
		'{KIND_SEED,      32'h0001_0000, 1'b1, '{ST_OK,          32'h0, 8'd0, 1'b1}},
		'{KIND_ALLOC,     32'h0000_0000, 1'b1, '{ST_OK,  32'h0001_0000, 8'd1, 1'b0}},
		'{KIND_ADD_REF,   32'h0001_0000, 1'b0, NO_REPLY},
		'{KIND_GET_REF,   32'h0001_0000, 1'b0, NO_REPLY},
		'{KIND_FREE,      32'h0001_0000, 1'b0, NO_REPLY},
		'{KIND_FREE,      32'h0001_0000, 1'b0, NO_REPLY},
		'{KIND_FREE,      32'h0001_0000, 1'b1, '{ST_DOUBLE_FREE, 32'h0, 8'd0, 1'b0}},
		'{KIND_ALLOC,     32'hFFFF_FFFF, 1'b0, NO_REPLY},
		'{KIND_ALLOC,     32'h0000_0000, 1'b0, NO_REPLY},
		'{KIND_ALLOC,     32'h0000_0000, 1'b1, '{ST_NO_MEM,      32'h0, 8'd0, 1'b0}},
		'{KIND_GET_REF,   32'hFFFF_FFFF, 1'b1, '{ST_BAD_ADDR,    32'h0, 8'd0, 1'b0}},
		'{KIND_ADD_REF,   32'h0000_0000, 1'b1, '{ST_BAD_ADDR,    32'h0, 8'd0, 1'b0}},
		'{KIND_UNUSED_LO, 32'h0001_0000, 1'b1, '{ST_OK,          32'h0, 8'd0, 1'b0}},
		'{KIND_UNUSED_HI, 32'hFFFF_FFFF, 1'b1, '{ST_OK,          32'h0, 8'd0, 1'b0}},
		'{KIND_SEED,      32'h0001_0000, 1'b0, NO_REPLY},
		'{KIND_SEED,      32'h0001_0000, 1'b0, NO_REPLY}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [ADDR_W-1:0]      s_axis_tdata;   // [31:0] address
	logic [KIND_W-1:0]      s_axis_tuser;   // [2:0] kind
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;   // [31:0] page_address, [39:32] ref_count,
	                                        // [40] page_released, [47:41] zero
	logic [STATUS_W-1:0]    m_axis_tuser;   // [2:0] status
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [REG_W-1:0]       pwdata;
	logic [REG_W-1:0]       prdata;
	logic                   pready;

	// Allocator state as the testbench tracks it
	logic [COUNT_WIDTH-1:0] page_refs [PAGE_COUNT];
	logic [PAGE_NUM_W-1:0]  free_pages [$];
	int unsigned            win_lowest;
	int unsigned            win_top;

	rsp_t                   pending_replies [$];
	int unsigned            fail_count;
	bit                     src_idle_on;
	bit                     snk_idle_on;
	bit                     sink_hold;

	refcounted_page_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Page lookup: range always, alignment only where the request needs it
	function automatic logic page_in_window(input logic [ADDR_W-1:0] addr,
			input logic need_align, output int unsigned slot);
		int unsigned pg;
		pg = addr >> PAGE_SHIFT;
		slot = pg - win_lowest;
		if (need_align && addr[PAGE_SHIFT-1:0] != '0)
			return 1'b0;
		return (pg >= win_lowest) && (pg < win_top) && (slot < PAGE_COUNT);
	endfunction

	// Applies one request to the tracked state and returns its reply
	function automatic rsp_t apply_page_request(input logic [KIND_W-1:0] kind,
			input logic [ADDR_W-1:0] addr);
		rsp_t                   r;
		int unsigned            slot;
		int unsigned            pg;
		logic [COUNT_WIDTH-1:0] cnt;
		r = '0;
		case (kind)
			KIND_ALLOC: begin
				if (free_pages.size() == 0) begin
					r.status = ST_NO_MEM;
				end else begin
					pg = free_pages.pop_back();
					r.page_address = ADDR_W'(pg) << PAGE_SHIFT;
					// stacked page may lie outside a window set later
					if (pg >= win_lowest && pg - win_lowest < PAGE_COUNT)
						page_refs[pg - win_lowest] = COUNT_ONE;
					r.ref_count = COUNT_OUT_W'(COUNT_ONE);
				end
			end
			KIND_FREE, KIND_ADD_REF, KIND_SEED: begin
				if (!page_in_window(addr, 1'b1, slot)) begin
					r.status = ST_BAD_ADDR;
				end else begin
					cnt = page_refs[slot];
					if (kind == KIND_ADD_REF) begin
						if (cnt == COUNT_MAX)
							r.status = ST_SATURATED;
						else
							cnt++;
						page_refs[slot] = cnt;
					end else if (kind == KIND_FREE && cnt == '0) begin
						r.status = ST_DOUBLE_FREE;
					end else if (kind == KIND_FREE && cnt != COUNT_ONE) begin
						cnt--;
						page_refs[slot] = cnt;
					end else if (free_pages.size() >= PAGE_COUNT) begin
						// push refused, count kept and reported
						r.status = ST_STACK_FULL;
					end else begin
						free_pages.push_back(PAGE_NUM_W'(addr >> PAGE_SHIFT));
						cnt = '0;
						page_refs[slot] = cnt;
						r.page_released = 1'b1;
					end
					r.ref_count = COUNT_OUT_W'(cnt);
				end
			end
			KIND_GET_REF: begin
				if (!page_in_window(addr, 1'b0, slot))
					r.status = ST_BAD_ADDR;
				else
					r.ref_count = COUNT_OUT_W'(page_refs[slot]);
			end
			default: ;
		endcase
		return r;
	endfunction

	// Random request: mostly pages of a small hot set, some whole window, some noise
	function automatic void pick_request(input int unsigned hot,
			output logic [KIND_W-1:0] kind, output logic [ADDR_W-1:0] addr);
		int unsigned span;
		int unsigned roll;
		int unsigned pg;
		span = (win_top > win_lowest) ? win_top - win_lowest : 0;
		if (span > PAGE_COUNT)
			span = PAGE_COUNT;
		roll = $urandom_range(0, 99);
		if (roll < 25)
			kind = KIND_ALLOC;
		else if (roll < 49)
			kind = KIND_FREE;
		else if (roll < 63)
			kind = KIND_ADD_REF;
		else if (roll < 78)
			kind = KIND_GET_REF;
		else if (roll < 96)
			kind = KIND_SEED;
		else
			kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
		roll = $urandom_range(0, 99);
		if (span == 0 || roll < 7) begin
			addr = $urandom;
		end else begin
			if (roll < 12)
				pg = ($urandom_range(0, 1) != 0) ? win_lowest + span : win_lowest - 1;
			else if (roll < 30)
				pg = win_lowest + $urandom_range(0, span - 1);
			else
				pg = win_lowest + $urandom_range(0, ((hot < span) ? hot : span) - 1);
			addr = ADDR_W'(pg) << PAGE_SHIFT;
			if ($urandom_range(0, 11) == 0)
				addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
		end
	endfunction

	// Offers one item; the reply is predicted when the item is taken
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
			input logic typed, input rsp_t typed_rsp);
		int   gap;
		rsp_t want;
		gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= addr;
		do @(posedge clk); while (!s_axis_tready);
		want = apply_page_request(kind, addr);
		pending_replies.push_back(typed ? typed_rsp : want);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= REG_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_TOP)
			win_top = value & ((1 << TOP_W) - 1);
		else
			win_lowest = value & ((1 << LOWEST_W) - 1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_window(input int unsigned lowest, input int unsigned top);
		wait_drained();
		write_reg(REG_LOWEST, lowest);
		write_reg(REG_TOP, top);
	endtask

	task automatic run_random(input int n, input int unsigned hot);
		logic [KIND_W-1:0] k;
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			// idling switches on and off in stretches
			if (i % STRETCH == 0) begin
				src_idle_on = ($urandom_range(0, 3) != 0);
				snk_idle_on = ($urandom_range(0, 3) != 0);
			end
			pick_request(hot, k, a);
			send_item(k, a, 1'b0, NO_REPLY);
		end
	endtask

	// Result side: random stalls, occasional long hold, field-by-field check
	initial begin : result_sink
		int   gap;
		rsp_t want;
		rsp_t got;
		@(posedge clk);
		forever begin
			if (sink_hold) begin
				gap = HOLD_CYCLES;
				sink_hold = 1'b0;
			end else begin
				gap = snk_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.status        = m_axis_tuser;
			got.page_address  = m_axis_tdata[ADDR_W-1:0];
			got.ref_count     = m_axis_tdata[ADDR_W +: COUNT_OUT_W];
			got.page_released = m_axis_tdata[ADDR_W + COUNT_OUT_W];
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result: status %0d addr %h count %0d released %0d",
						got.status, got.page_address, got.ref_count, got.page_released);
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status || got.page_address !== want.page_address
						|| got.ref_count !== want.ref_count
						|| got.page_released !== want.page_released) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display({"mismatch: status %0d/%0d addr %h/%h count %0d/%0d",
							" released %0d/%0d (expected/actual)"},
							want.status, got.status, want.page_address, got.page_address,
							want.ref_count, got.ref_count, want.page_released,
							got.page_released);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("refcounted_page_allocator_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		logic [KIND_W-1:0] k;
		logic [ADDR_W-1:0] a;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		m_axis_tready <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		arst_n        <= 1'b0;
		foreach (page_refs[i])
			page_refs[i] = '0;
		win_lowest  = 0;
		win_top     = 0;
		fail_count  = 0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		sink_hold   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; the first ones run with the reset window
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == CFG_ROW)
				set_window(DIR_LOWEST, DIR_TOP);
			send_item(DIRECTED[i].kind, DIRECTED[i].addr, DIRECTED[i].typed,
				DIRECTED[i].rsp);
		end

		// Top past lowest + PAGE_COUNT: the count store bounds the window
		set_window(32'h300, 32'h300 + PAGE_COUNT + 128);
		run_random(200, 16);
		// long sink hold while items keep coming: queue fills, input stalls
		sink_hold   = 1'b1;
		src_idle_on = 1'b0;
		repeat (40) begin
			pick_request(16, k, a);
			send_item(k, a, 1'b0, NO_REPLY);
		end
		wait_drained();
		run_random(150, 16);

		// One-page window at the very top
		set_window(LOWEST_MAX, TOP_MAX);
		run_random(120, 1);

		// Empty window: of the known kinds only allocate of stacked pages succeeds
		set_window(0, 0);
		run_random(60, 4);

		// Small window; saturate one count first
		set_window(32'h12345, 32'h12345 + 40);
		src_idle_on = 1'b0;
		repeat (COUNT_MAX + 3)
			send_item(KIND_ADD_REF, ADDR_W'(win_lowest + 3) << PAGE_SHIFT, 1'b0, NO_REPLY);
		run_random(200, 8);

		// Widest window
		set_window(0, TOP_MAX);
		run_random(250, 24);

		// Seed, share and release one page back to back
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		send_item(KIND_SEED, ADDR_W'(1) << PAGE_SHIFT, 1'b0, NO_REPLY);
		send_item(KIND_ADD_REF, ADDR_W'(1) << PAGE_SHIFT, 1'b0, NO_REPLY);
		send_item(KIND_FREE, ADDR_W'(1) << PAGE_SHIFT, 1'b0, NO_REPLY);
		send_item(KIND_SEED, ADDR_W'(1) << PAGE_SHIFT, 1'b0, NO_REPLY);
		run_random(100, 4);

		wait_drained();
		if (fail_count == 0 && pending_replies.size() == 0)
			$display("refcounted_page_allocator_tb: done, clean");
		else
			$display("refcounted_page_allocator_tb: done, errors");
		$finish;
	end

endmodule
